// ===== hdl/perspective_point_project_core_macros.svh =====
// assertion macros for the perspective point projection core
`ifndef PERSPECTIVE_POINT_PROJECT_CORE_MACROS_SVH
`define PERSPECTIVE_POINT_PROJECT_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define PPPC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// implication checked on every clock edge outside reset
`define PPPC_ASSERT_IMPL(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);
`else
`define PPPC_ASSERT(lbl, prop, msg)
`define PPPC_ASSERT_IMPL(lbl, pre, post, msg)
`endif
`endif

// ===== hdl/pppc_pkg.sv =====
// shared types, constants and helpers of the projection core
package pppc_pkg;

   // quotient bits of the pixel divider, one per pipeline stage
   localparam int unsigned DIV_STEPS = 40;
   // cycles from a start transfer to its result strobe
   localparam int unsigned LATENCY = DIV_STEPS + 5;

   // register indexes
   localparam logic [2:0] REG_ORIGIN_XY     = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Z_NEAR = 3'd1;
   localparam logic [2:0] REG_RIGHT_VECTOR  = 3'd2;
   localparam logic [2:0] REG_UP_VECTOR     = 3'd3;
   localparam logic [2:0] REG_FORWARD_VECTOR = 3'd4;
   localparam logic [2:0] REG_TAN_HALF_FOV  = 3'd5;
   localparam logic [2:0] REG_VIEWPORT_SIZE = 3'd6;

   // register reset values
   localparam logic [63:0] RST_ORIGIN_XY     = 64'd0;
   localparam logic [63:0] RST_ORIGIN_Z_NEAR = 64'd28149215657984;
   localparam logic [47:0] RST_RIGHT_VECTOR  = 48'd16384;
   localparam logic [47:0] RST_UP_VECTOR     = 48'd70368744177664;
   localparam logic [47:0] RST_FORWARD_VECTOR = 48'd3221225472;
   localparam logic [63:0] RST_TAN_HALF_FOV  = 64'd37510809852920802;
   localparam logic [31:0] RST_VIEWPORT_SIZE = 32'd0;

   // camera-space coordinates, Q16.16
   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
   } cam_type;

   // per-item flags carried alongside the divider
   typedef struct packed {
      logic        zero_vp;
      logic        proj;
      logic [31:0] depth;
      logic        neg_x;
      logic        neg_y;
      logic        cap_x;
      logic        cap_y;
      logic        in_view;
   } side_type;

   // clamp to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
      logic signed [31:0] r;
      if (v > 43'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -43'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/pppc_front.sv =====
// offset, basis products and rounding to camera space (three stages)
module pppc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_in,
   input  logic signed [31:0] point_x,
   input  logic signed [31:0] point_y,
   input  logic signed [31:0] point_z,
   input  logic [31:0]        origin_x,
   input  logic [31:0]        origin_y,
   input  logic [31:0]        origin_z,
   input  logic [47:0]        right_vec,
   input  logic [47:0]        up_vec,
   input  logic [47:0]        fwd_vec,
   output logic               valid_out,
   output pppc_pkg::cam_type  cam
);

   logic               v1_ff, v2_ff, v3_ff;
   logic signed [32:0] off_ff [3];
   logic signed [48:0] prod_ff [3][3];
   pppc_pkg::cam_type  cam_ff;
   logic [47:0]        vecs [3];
   logic signed [31:0] cam_in [3];

   assign vecs[0] = right_vec;
   assign vecs[1] = up_vec;
   assign vecs[2] = fwd_vec;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= valid_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // stage 1: offset from the camera origin
   always_ff @(posedge clock) begin
      off_ff[0] <= $signed({point_x[31], point_x}) - $signed({origin_x[31], origin_x});
      off_ff[1] <= $signed({point_y[31], point_y}) - $signed({origin_y[31], origin_y});
      off_ff[2] <= $signed({point_z[31], point_z}) - $signed({origin_z[31], origin_z});
   end

   // stage 2: nine products against the Q1.14 basis
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_ff[i][j] <= off_ff[j] * $signed(vecs[i][16*j +: 16]);
         end
      end
   end

   // stage 3: sum, round half up to Q16.16, saturate
   always_comb begin
      logic signed [50:0] sum;
      logic signed [50:0] rnd;
      for (int i = 0; i < 3; i++) begin
         sum = {{2{prod_ff[i][0][48]}}, prod_ff[i][0]}
             + {{2{prod_ff[i][1][48]}}, prod_ff[i][1]}
             + {{2{prod_ff[i][2][48]}}, prod_ff[i][2]};
         rnd = (sum + 51'sd8192) >>> 14;
         cam_in[i] = pppc_pkg::sat32(rnd[42:0]);
      end
   end

   always_ff @(posedge clock) begin
      cam_ff.cx <= cam_in[0];
      cam_ff.cy <= cam_in[1];
      cam_ff.cz <= cam_in[2];
   end

   assign valid_out = v3_ff;
   assign cam       = cam_ff;

endmodule

// ===== hdl/pppc_div.sv =====
// pipelined restoring divider, one quotient bit per stage, n < 2d assumed
module pppc_div (
   input  logic                             clock,
   input  logic [47:0]                      num,
   input  logic [62:0]                      den,
   output logic [pppc_pkg::DIV_STEPS-1:0]   quo
);

   localparam int unsigned N = pppc_pkg::DIV_STEPS;

   logic [63:0]  rem_ff [N];
   logic [N-1:0] quo_ff [N];
   logic [62:0]  den_ff [N];

   genvar k;
   generate
      for (k = 0; k < N; k++) begin : g_step
         logic [63:0]  trial;
         logic [64:0]  diff;
         logic [62:0]  d_prev;
         logic [N-1:0] q_prev;

         // first step compares without a shift
         if (k == 0) begin : g_first
            assign trial  = {16'd0, num};
            assign d_prev = den;
            assign q_prev = '0;
         end else begin : g_next
            assign trial  = {rem_ff[k-1][62:0], 1'b0};
            assign d_prev = den_ff[k-1];
            assign q_prev = quo_ff[k-1];
         end

         assign diff = {1'b0, trial} - {2'b00, d_prev};

         always_ff @(posedge clock) begin
            rem_ff[k] <= diff[64] ? trial : diff[63:0];
            quo_ff[k] <= {q_prev[N-2:0], ~diff[64]};
            den_ff[k] <= d_prev;
         end
      end
   endgenerate

   assign quo = quo_ff[N-1];

endmodule

// ===== hdl/perspective_point_project_core.sv =====
// top level of the perspective point projection core
// Projects one world point to screen pixels per clock. A point taken on a
// start transfer passes three camera-space stages, one multiply stage and
// the two 40-stage divider pipelines (one quotient bit per stage) before
// it comes out on rsp_strobe from the output register. busy is high only
// in reset, so a new point may be started every cycle, and results cannot be
// held off: each one stands on the rsp_ ports for a single cycle. Registers
// are written through the csr_ channel, which is always ready, and must only
// change while no point is in flight.
`include "perspective_point_project_core_macros.svh"
module perspective_point_project_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   output logic               rsp_strobe,
   output logic               rsp_projected_ok,
   output logic signed [31:0] rsp_screen_x,
   output logic signed [31:0] rsp_screen_y,
   output logic signed [31:0] rsp_camera_depth,
   output logic               rsp_inside_view,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data
);

   localparam int unsigned N = pppc_pkg::DIV_STEPS;

   logic        accept;
   logic [63:0] origin_xy_ff, origin_z_near_ff, tan_ff;
   logic [47:0] right_ff, up_ff, fwd_ff;
   logic [31:0] vp_ff;
   logic [15:0] vp_w, vp_h;
   logic [31:0] near, tan_x, tan_y;

   logic              cam_valid;
   pppc_pkg::cam_type cam;

   logic        s4_valid_ff;
   logic [62:0] dx_ff, dy_ff;
   logic [47:0] nx_ff, ny_ff;
   logic [31:0] magx_ff, magy_ff;
   logic [31:0] depth_ff;
   logic        negx_ff, negy_ff, zero_ff, proj_ff;
   logic [31:0] magx_in, magy_in;

   pppc_pkg::side_type side_ff [N];
   logic [N-1:0]       side_v_ff;
   pppc_pkg::side_type side_in;

   logic [N-1:0] quo_x, quo_y;

   logic               out_v_ff, out_ok_ff, out_in_view_ff;
   logic signed [31:0] out_sx_ff, out_sy_ff, out_depth_ff;
   logic signed [31:0] sx_in, sy_in;

   assign accept    = start && !busy;
   assign busy      = reset;
   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_xy_ff     <= pppc_pkg::RST_ORIGIN_XY;
         origin_z_near_ff <= pppc_pkg::RST_ORIGIN_Z_NEAR;
         right_ff         <= pppc_pkg::RST_RIGHT_VECTOR;
         up_ff            <= pppc_pkg::RST_UP_VECTOR;
         fwd_ff           <= pppc_pkg::RST_FORWARD_VECTOR;
         tan_ff           <= pppc_pkg::RST_TAN_HALF_FOV;
         vp_ff            <= pppc_pkg::RST_VIEWPORT_SIZE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pppc_pkg::REG_ORIGIN_XY:      origin_xy_ff     <= csr_data;
            pppc_pkg::REG_ORIGIN_Z_NEAR:  origin_z_near_ff <= csr_data;
            pppc_pkg::REG_RIGHT_VECTOR:   right_ff         <= csr_data[47:0];
            pppc_pkg::REG_UP_VECTOR:      up_ff            <= csr_data[47:0];
            pppc_pkg::REG_FORWARD_VECTOR: fwd_ff           <= csr_data[47:0];
            pppc_pkg::REG_TAN_HALF_FOV:   tan_ff           <= csr_data;
            pppc_pkg::REG_VIEWPORT_SIZE:  vp_ff            <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   assign vp_w  = vp_ff[15:0];
   assign vp_h  = vp_ff[31:16];
   assign near  = origin_z_near_ff[63:32];
   // a zero tangent acts as one lsb
   assign tan_x = (tan_ff[31:0] == 32'd0) ? 32'd1 : tan_ff[31:0];
   assign tan_y = (tan_ff[63:32] == 32'd0) ? 32'd1 : tan_ff[63:32];

   // stages 1 to 3: camera space
   pppc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (accept),
      .point_x   (req_point_x),
      .point_y   (req_point_y),
      .point_z   (req_point_z),
      .origin_x  (origin_xy_ff[31:0]),
      .origin_y  (origin_xy_ff[63:32]),
      .origin_z  (origin_z_near_ff[31:0]),
      .right_vec (right_ff),
      .up_vec    (up_ff),
      .fwd_vec   (fwd_ff),
      .valid_out (cam_valid),
      .cam       (cam)
   );

   // stage 4: scaled depths, scaled magnitudes and reject flags
   assign magx_in = cam.cx[31] ? (~cam.cx + 32'd1) : cam.cx;
   assign magy_in = cam.cy[31] ? (~cam.cy + 32'd1) : cam.cy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= cam_valid;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff    <= cam.cz[30:0] * tan_x;
      dy_ff    <= cam.cz[30:0] * tan_y;
      nx_ff    <= magx_in * vp_w;
      ny_ff    <= magy_in * vp_h;
      magx_ff  <= magx_in;
      magy_ff  <= magy_in;
      negx_ff  <= cam.cx[31];
      negy_ff  <= cam.cy[31];
      depth_ff <= cam.cz;
      zero_ff  <= (vp_w == 16'd0) || (vp_h == 16'd0);
      proj_ff  <= !cam.cz[31] && ({1'b0, cam.cz[30:0]} > near);
   end

   // pixel offset dividers
   pppc_div u_div_x (.clock(clock), .num(nx_ff), .den(dx_ff), .quo(quo_x));
   pppc_div u_div_y (.clock(clock), .num(ny_ff), .den(dy_ff), .quo(quo_y));

   // flags that ride alongside the dividers, with cap and bounds tests
   always_comb begin
      side_in.zero_vp = zero_ff;
      side_in.proj    = proj_ff;
      side_in.depth   = depth_ff;
      side_in.neg_x   = negx_ff;
      side_in.neg_y   = negy_ff;
      side_in.cap_x   = {16'd0, nx_ff} >= {dx_ff, 1'b0};
      side_in.cap_y   = {16'd0, ny_ff} >= {dy_ff, 1'b0};
      side_in.in_view = ({7'd0, magx_ff, 24'd0} <= dx_ff)
                     && ({7'd0, magy_ff, 24'd0} <= dy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_v_ff <= '0;
      end else begin
         side_v_ff <= {side_v_ff[N-2:0], s4_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int k = 1; k < N; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   // final stage: center offset and saturation
   always_comb begin
      logic [40:0]        term_x, term_y;
      logic signed [42:0] sterm_x, sterm_y;
      logic signed [42:0] base_x, base_y;
      term_x  = side_ff[N-1].cap_x ? (41'd1 << 40) : {1'b0, quo_x};
      term_y  = side_ff[N-1].cap_y ? (41'd1 << 40) : {1'b0, quo_y};
      sterm_x = side_ff[N-1].neg_x ? -$signed({2'b00, term_x}) : $signed({2'b00, term_x});
      sterm_y = side_ff[N-1].neg_y ? -$signed({2'b00, term_y}) : $signed({2'b00, term_y});
      base_x  = $signed({12'd0, vp_w, 15'd0});
      base_y  = $signed({12'd0, vp_h, 15'd0});
      sx_in   = pppc_pkg::sat32(base_x + sterm_x);
      sy_in   = pppc_pkg::sat32(base_y - sterm_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= side_v_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (side_ff[N-1].zero_vp) begin
         out_ok_ff      <= 1'b0;
         out_sx_ff      <= '0;
         out_sy_ff      <= '0;
         out_depth_ff   <= '0;
         out_in_view_ff <= 1'b0;
      end else begin
         out_ok_ff      <= side_ff[N-1].proj;
         out_sx_ff      <= side_ff[N-1].proj ? sx_in : '0;
         out_sy_ff      <= side_ff[N-1].proj ? sy_in : '0;
         out_depth_ff   <= side_ff[N-1].depth;
         out_in_view_ff <= side_ff[N-1].proj && side_ff[N-1].in_view;
      end
   end

   assign rsp_strobe       = out_v_ff;
   assign rsp_projected_ok = out_ok_ff;
   assign rsp_screen_x     = out_sx_ff;
   assign rsp_screen_y     = out_sy_ff;
   assign rsp_camera_depth = out_depth_ff;
   assign rsp_inside_view  = out_in_view_ff;

   // checks
   `PPPC_ASSERT_IMPL(a_rsp_from_start, rsp_strobe, $past(accept, pppc_pkg::LATENCY), "result strobe without a start transfer")
   `PPPC_ASSERT_IMPL(a_reject_zero, rsp_strobe && !rsp_projected_ok, (rsp_screen_x == 32'sd0) && (rsp_screen_y == 32'sd0) && !rsp_inside_view, "rejected point with nonzero screen outputs")
   `PPPC_ASSERT(a_proj_depth_pos, !(rsp_strobe && rsp_projected_ok && (rsp_camera_depth[31] || (rsp_camera_depth == 32'sd0))), "projected point without positive depth")

endmodule
